>>> hw/rtl/bwp_pkg.sv
// Shared types and constants for the bit width packer.
package bwp_pkg;

	localparam int unsigned WordBits  = 32;
	localparam int unsigned WidthBits = 5;
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned PtrBits   = $clog2(FifoDepth);
	localparam int unsigned CntBits   = $clog2(FifoDepth + 1);

	localparam logic [WidthBits-1:0] BitWidthReset = 5'd8;

	typedef struct packed {
		logic [WordBits-1:0] value;
		logic                last;
	} item_t;

	typedef struct packed {
		logic [WordBits-1:0] word;
		logic                word_last;
		logic                error;
	} result_t;

	// What one item leaves for the output queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} pack_out_t;

endpackage

>>> hw/rtl/bwp_packer.sv
// Packing datapath with the accumulator and fill count.
module bwp_packer import bwp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  item_t                item,
	input  logic [WidthBits-1:0] bit_width,
	output pack_out_t            res
);

	logic [WordBits-1:0]   acc_q;
	logic [WidthBits-1:0]  fill_q;

	logic [WordBits-1:0]   taken;
	logic [2*WordBits-1:0] combined;
	logic [WidthBits:0]    total;
	logic [WordBits-1:0]   acc_d;
	logic [WidthBits-1:0]  fill_d;
	logic                  full;

	always_comb begin
		taken    = item.value & ((32'h1 << bit_width) - 32'h1);
		// acc_q holds zeros above fill_q, so a plain OR is enough
		combined = {32'h0, acc_q} | ({32'h0, taken} << fill_q);
		total    = {1'b0, fill_q} + {1'b0, bit_width};
		full     = total[WidthBits];
		acc_d    = full ? combined[2*WordBits-1:WordBits] : combined[WordBits-1:0];
		fill_d   = total[WidthBits-1:0];

		res = '0;
		if (item.value[WordBits-1]) begin
			res.count        = 2'd1;
			res.first.word_last = 1'b1;
			res.first.error  = 1'b1;
		end else if (full) begin
			res.first.word      = combined[WordBits-1:0];
			res.first.word_last = item.last && (fill_d == '0);
			res.count           = 2'd1;
			if (item.last && fill_d != '0) begin
				res.second.word      = acc_d;
				res.second.word_last = 1'b1;
				res.count            = 2'd2;
			end
		end else if (item.last && fill_d != '0) begin
			res.first.word      = acc_d;
			res.first.word_last = 1'b1;
			res.count           = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (fire) begin
			if (item.value[WordBits-1] || item.last) begin
				acc_q  <= '0;
				fill_q <= '0;
			end else begin
				acc_q  <= acc_d;
				fill_q <= fill_d;
			end
		end
	end

endmodule

>>> hw/rtl/bit_width_packer_unit.sv
// Top level of the bit width packer: input stage, config register, result queue.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------
//  item     | item_valid / item_stall      | item_t   {value, last}
//  result   | result_valid / result_stall  | result_t {word, word_last, error}
//  cfg      | cfg_valid / cfg_ready        | cfg_data = bit_width
//
// One item per cycle unless stalled: the input stage registers an item, then the
// packer writes its 0, 1 or 2 results into a 4-entry queue; results appear the cycle after.
// Two results per item can only drain at one per cycle, so the queue fill sets the
// sustained rate when many items flush. Reset clears the state, the queue and sets
// bit_width to 8. item_stall rises only while the queue lacks room for two results.
module bit_width_packer_unit import bwp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [WidthBits-1:0] cfg_data
);

	logic [WidthBits-1:0] bit_width_q;
	item_t                item_s1;
	logic                 valid_s1;
	logic                 advance;
	pack_out_t            pack;

	result_t              fifo_q [FifoDepth];
	logic [PtrBits-1:0]   wr_ptr_q;
	logic [PtrBits-1:0]   rd_ptr_q;
	logic [CntBits-1:0]   count_q;
	logic                 pop;
	logic [CntBits-1:0]   push_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_width_q <= BitWidthReset;
		end else if (cfg_valid && cfg_ready) begin
			bit_width_q <= cfg_data;
		end
	end

	assign pop          = result_valid && !result_stall;
	assign result_valid = (count_q != '0);
	assign result       = fifo_q[rd_ptr_q];

	// room for two more entries, counting the transfer leaving this cycle
	assign advance    = valid_s1 &&
		((count_q <= CntBits'(FifoDepth - 2)) || (count_q == CntBits'(FifoDepth - 1) && pop));
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	bwp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.bit_width (bit_width_q),
		.res       (pack)
	);

	assign push_cnt = advance ? CntBits'(pack.count) : '0;

	always_ff @(posedge clk) begin
		if (advance && pack.count != 2'd0) begin
			fifo_q[wr_ptr_q] <= pack.first;
		end
		if (advance && pack.count == 2'd2) begin
			fifo_q[wr_ptr_q + PtrBits'(1)] <= pack.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrBits'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrBits'(1);
			end
			count_q <= count_q + push_cnt - CntBits'(pop);
		end
	end

endmodule

>>> hw/rtl/bwp_checker.sv
// Port-level checks for the bit width packer, bound to the top level.
module bwp_checker import bwp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// an error result carries a zero word and closes the sequence
	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error |-> result.word == '0 && result.word_last)
		else $error("error result with nonzero word or without word_last");

	// the item side only stalls while results wait in the queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item stalled with no result pending");

	// a stalled result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind bit_width_packer_unit bwp_checker u_bwp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> tb/tb.sv
// Self-checking testbench for bit_width_packer_unit: directed table, then random packing runs.
`timescale 1ns / 1ps

module tb;
	import bwp_pkg::*;

	localparam int CycleLimit  = 500000;
	localparam int IdleCycles  = 8;
	localparam int PhaseItems  = 150;
	localparam int PhaseCount  = 8;
	localparam int Predicted   = -1;

	localparam result_t ErrResult = '{word: '0, word_last: 1'b1, error: 1'b1};
	localparam result_t NoWord    = '0;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	// typed: Predicted, or the number of results given in word (0 or 1)
	typedef struct {
		row_kind_t           kind;
		logic [WordBits-1:0] value;
		logic                last;
		int                  typed;
		result_t             word;
	} row_t;

	row_t plan [30] = '{
		'{ROW_ITEM, 32'h0000_00FF, 1'b1, 1, '{32'h0000_00FF, 1'b1, 1'b0}},
		'{ROW_ITEM, 32'h8000_0000, 1'b0, 1, ErrResult},
		'{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 1, ErrResult},
		'{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 1, '{32'h0000_00FF, 1'b1, 1'b0}},
		'{ROW_ITEM, 32'h0000_0011, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_0022, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_0033, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_0044, 1'b1, 1, '{32'h4433_2211, 1'b1, 1'b0}},
		'{ROW_ITEM, 32'h0000_0055, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h8000_0001, 1'b1, 1, ErrResult},
		'{ROW_ITEM, 32'h0000_0066, 1'b1, 1, '{32'h0000_0066, 1'b1, 1'b0}},
		'{ROW_ITEM, 32'h0000_00AB, 1'b0, Predicted, NoWord},
		'{ROW_CFG,  32'd0,         1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0001_2345, 1'b1, 1, '{32'h0000_00AB, 1'b1, 1'b0}},
		'{ROW_ITEM, 32'h0001_2345, 1'b1, Predicted, NoWord},
		'{ROW_ITEM, 32'h8000_0000, 1'b0, 1, ErrResult},
		'{ROW_CFG,  32'd31,        1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_0000, 1'b1, 1, '{32'h0000_0000, 1'b1, 1'b0}},
		'{ROW_CFG,  32'd1,         1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_0001, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_0000, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_0001, 1'b1, Predicted, NoWord},
		'{ROW_CFG,  32'd20,        1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_0001, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h000F_FFFF, 1'b1, Predicted, NoWord},
		'{ROW_CFG,  32'd16,        1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_ABCD, 1'b0, Predicted, NoWord},
		'{ROW_ITEM, 32'h0000_1234, 1'b1, Predicted, NoWord}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [WidthBits-1:0] cfg_data;

	// packer state as the testbench sees it
	logic [WidthBits-1:0] pack_width = BitWidthReset;
	logic [WordBits-1:0]  held_bits  = '0;
	logic [WidthBits-1:0] held_count = '0;

	result_t pending_words [$];

	int failures     = 0;
	int items_sent   = 0;
	int bad_values   = 0;
	int words_seen   = 0;
	int widths_set   = 0;
	int cycles       = 0;
	int src_left     = 0;
	bit src_calm     = 1'b0;
	int sink_left    = 0;
	bit sink_calm    = 1'b0;

	bit_width_packer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("FAIL bit_width_packer_unit");
			$finish;
		end
	end

	// Wait cycles before the next transfer; stretches of zero waits come and go.
	function automatic int draw_wait(ref int left, ref bit calm);
		if (left == 0) begin
			left = $urandom_range(20, 80);
			calm = ($urandom_range(0, 2) == 0);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	// Packs one value into the held bits; returns how many words it releases.
	function automatic int pack_value(input item_t it, output result_t w0, output result_t w1);
		logic [63:0] taken;
		logic [63:0] merged;
		int unsigned total;
		int          n;
		n  = 0;
		w0 = NoWord;
		w1 = NoWord;
		if (it.value[WordBits-1]) begin
			held_bits  = '0;
			held_count = '0;
			w0 = ErrResult;
			return 1;
		end
		taken  = {32'd0, it.value} & ((64'd1 << pack_width) - 64'd1);
		merged = ({32'd0, held_bits} & ((64'd1 << held_count) - 64'd1)) | (taken << held_count);
		total  = held_count + pack_width;
		if (total >= WordBits) begin
			w0 = '{word: merged[31:0], word_last: it.last && total == WordBits, error: 1'b0};
			n = 1;
			merged = merged >> WordBits;
			total  = total - WordBits;
		end
		held_bits  = merged[31:0];
		held_count = total[WidthBits-1:0];
		if (it.last) begin
			if (held_count != 0) begin
				if (n == 0)
					w0 = '{word: held_bits, word_last: 1'b1, error: 1'b0};
				else
					w1 = '{word: held_bits, word_last: 1'b1, error: 1'b0};
				n++;
			end
			held_bits  = '0;
			held_count = '0;
		end
		return n;
	endfunction

	// Called at a rising edge; returns at the edge where the item transfers.
	task automatic send_item(input item_t it, input int typed, input result_t typed_word);
		int      gap;
		int      n;
		result_t w0;
		result_t w1;
		gap = draw_wait(src_left, src_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
		if (it.value[WordBits-1])
			bad_values++;
		n = pack_value(it, w0, w1);
		if (typed == Predicted) begin
			if (n > 0) pending_words.push_back(w0);
			if (n > 1) pending_words.push_back(w1);
		end else if (typed == 1) begin
			pending_words.push_back(typed_word);
		end
	endtask

	// Drop valid, let every expected word arrive, then allow for items still in flight.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (IdleCycles) @(posedge clk);
	endtask

	task automatic write_width(input logic [WidthBits-1:0] w);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pack_width = w;
		widths_set++;
	endtask

	initial begin : sink
		int      hold;
		result_t want;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = draw_wait(sink_left, sink_calm);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			words_seen++;
			if (pending_words.size() == 0) begin
				$error("unexpected transfer: word %h word_last %b error %b",
					result.word, result.word_last, result.error);
				failures++;
			end else begin
				want = pending_words.pop_front();
				if (result.word !== want.word) begin
					$error("word: expected %h, got %h", want.word, result.word);
					failures++;
				end
				if (result.word_last !== want.word_last) begin
					$error("word_last: expected %b, got %b", want.word_last, result.word_last);
					failures++;
				end
				if (result.error !== want.error) begin
					$error("error: expected %b, got %b", want.error, result.error);
					failures++;
				end
			end
		end
	end

	initial begin : stimulus
		item_t it;
		int    sent;
		int    len;
		int    pick;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_idle();
				write_width(plan[i].value[WidthBits-1:0]);
			end else begin
				it.value = plan[i].value;
				it.last  = plan[i].last;
				send_item(it, plan[i].typed, plan[i].word);
			end
		end

		for (int p = 0; p < PhaseCount; p++) begin
			wait_idle();
			case (p)
				0:       write_width(5'd31);
				1:       write_width(5'd1);
				2:       write_width(5'd0);
				default: write_width(WidthBits'($urandom_range(1, 31)));
			endcase
			sent = 0;
			// mostly runs of good values closed by last; a stray last or bad value breaks some
			while (sent < PhaseItems) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
				for (int k = 0; k < len && sent < PhaseItems; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 3)
						it.value = {1'b1, 31'($urandom)};
					else if (pick < 6)
						it.value = '0;
					else if (pick < 9)
						it.value = 32'h7FFF_FFFF;
					else
						it.value = $urandom & 32'h7FFF_FFFF;
					it.last = (k == len - 1) || ($urandom_range(0, 49) == 0);
					send_item(it, Predicted, NoWord);
					sent++;
				end
			end
		end

		wait_idle();
		$display("covered %0d items (%0d out-of-range values) across %0d width settings",
			items_sent, bad_values, widths_set);
		$display("%0d packed words checked, %0d mismatches", words_seen, failures);
		if (failures == 0)
			$display("PASS bit_width_packer_unit");
		else
			$display("FAIL bit_width_packer_unit");
		$finish;
	end

endmodule
